// ===== design/sorted_table_binary_search_unit_assert.svh =====
// assertion macros for the sorted table binary search unit
// no dependencies; included by sbs_search_ctrl, which checks its own logic
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define SBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbs assertion failed");
// next-cycle implication, off during reset
`define SBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbs assertion failed");
`else
`define SBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sbs_pkg.sv =====
// shared types and constants of the sorted table binary search unit
// no dependencies; used by all modules of the block
package sbs_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ITER_W     = 4;
  localparam int unsigned COMP_W     = 5;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // transaction kinds carried in in_tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    SBS_IDLE,
    SBS_PROBE,
    SBS_COMPARE,
    SBS_DONE
  } sbs_state_t;

  typedef struct packed {
    logic [COMP_W-1:0]  comparison_count;
    logic [ITER_W-1:0]  iteration_count;
    logic [INDEX_W-1:0] found_index;
    logic               found;
  } sbs_result_t;

endpackage

// ===== design/sorted_table_binary_search_unit.sv =====
// top level of the sorted table binary search unit: channels, config, result register
// depends on sbs_pkg, sbs_table_ram and sbs_search_ctrl
//
//   channel | ports                          | contents
//   --------+--------------------------------+--------------------------------------
//   input   | in_tvalid/in_tready/in_tdata   | write an entry or search a target
//           | in_tuser                       |
//   result  | out_tvalid/out_tready/out_tdata| one per search, none per write
//   config  | cfg_valid/cfg_ready/cfg_data   | entry_count, always ready
//
// a write goes straight into the table; a search makes up to log2(depth)+1 probes,
// each a probe state (one table read) and a compare state, then a done state;
// the single read port of the table sets this
// a new transaction is taken only while no search is in progress
// the result register frees the search engine while it is empty or once out_tready takes its content
// synchronous reset clears control state; the table is undefined until written
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [9:0] entry_index, [41:10] value, [47:42] zero
  input  logic [sbs_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] mode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] found, [10:1] found_index, [14:11] iteration_count,
  // [19:15] comparison_count, [23:20] zero
  output logic [sbs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbs_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NUM_W  = $clog2(TABLE_DEPTH + 1);

  logic [sbs_pkg::COUNT_W-1:0]  entry_count_r;
  logic                         in_accept;
  logic                         idle;
  logic [sbs_pkg::INDEX_W-1:0]  in_index;
  logic [sbs_pkg::VALUE_W-1:0]  in_value;
  logic                         wr_en;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [sbs_pkg::VALUE_W-1:0]  rd_data;
  logic [NUM_W-1:0]             num_entries;
  logic                         start;
  logic                         res_valid;
  logic                         res_ready;
  sbs_pkg::sbs_result_t         result;
  logic                         out_valid_r;
  sbs_pkg::sbs_result_t         out_result_r;

  assign in_index  = in_tdata[sbs_pkg::INDEX_W-1:0];
  assign in_value  = in_tdata[sbs_pkg::INDEX_W +: sbs_pkg::VALUE_W];
  assign in_tready = idle;
  assign in_accept = in_tvalid && in_tready;
  assign start     = in_accept && (in_tuser == sbs_pkg::MODE_SEARCH);
  assign wr_en     = in_accept && (in_tuser == sbs_pkg::MODE_WRITE)
                     && (32'(in_index) < 32'(TABLE_DEPTH));

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_data;
    end
  end

  // entries in use, limited to the table depth
  always_comb begin
    if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      num_entries = NUM_W'(TABLE_DEPTH);
    end else begin
      num_entries = NUM_W'(entry_count_r);
    end
  end

  sbs_table_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(in_index)),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbs_search_ctrl #(
    .ADDR_W      (ADDR_W),
    .NUM_W       (NUM_W)
  ) u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .num_entries (num_entries),
    .target      (in_value),
    .idle        (idle),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .result      (result)
  );

  // result register between the search engine and the output channel
  assign res_ready = !out_valid_r || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sbs_pkg::OUT_DATA_W - $bits(sbs_pkg::sbs_result_t)){1'b0}},
                       out_result_r};

endmodule

// ===== design/sbs_table_ram.sv =====
// table storage: one write port, one read port, registered read data
// depends on sbs_pkg for the entry width
module sbs_table_ram #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned ADDR_W      = 10
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [sbs_pkg::VALUE_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [sbs_pkg::VALUE_W-1:0]    rd_data
);

  logic [sbs_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [sbs_pkg::VALUE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sbs_search_ctrl.sv =====
// binary search sequencer: issues probe reads and narrows the range
// depends on sbs_pkg and the assertion macro header
`include "sorted_table_binary_search_unit_assert.svh"

module sbs_search_ctrl #(
  parameter int unsigned ADDR_W      = 10,
  parameter int unsigned NUM_W       = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num_entries,
  input  logic [sbs_pkg::VALUE_W-1:0] target,
  output logic                        idle,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [sbs_pkg::VALUE_W-1:0] rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output sbs_pkg::sbs_result_t        result
);

  sbs_pkg::sbs_state_t state_r, state_nxt;

  logic [NUM_W-1:0]              low_r, low_nxt;
  logic [NUM_W-1:0]              hx_r, hx_nxt;      // one past the upper bound
  logic [NUM_W-1:0]              mid_r, mid_nxt;
  logic [sbs_pkg::VALUE_W-1:0]   target_r, target_nxt;
  logic                          found_r, found_nxt;
  logic [sbs_pkg::INDEX_W-1:0]   index_r, index_nxt;
  logic [sbs_pkg::ITER_W-1:0]    iters_r, iters_nxt;
  logic [sbs_pkg::COMP_W-1:0]    comps_r, comps_nxt;

  logic [NUM_W:0]                mid_sum;
  logic [NUM_W-1:0]              mid;
  logic                          hit;
  logic                          below;
  logic [NUM_W-1:0]              mid_inc;
  logic [sbs_pkg::COMP_W:0]      comps_add;

  // rounded-down midpoint of low and the inclusive upper bound
  assign mid_sum = {1'b0, low_r} + {1'b0, hx_r} - {{NUM_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[NUM_W:1];
  assign mid_inc = mid_r + {{(NUM_W-1){1'b0}}, 1'b1};

  // compare of the probed entry against the target
  assign hit   = (rd_data == target_r);
  assign below = ($signed(rd_data) < $signed(target_r));

  always_comb begin
    comps_add = {1'b0, comps_r} + (hit ? (sbs_pkg::COMP_W+1)'(1) : (sbs_pkg::COMP_W+1)'(2));
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbs_pkg::SBS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    low_r    <= low_nxt;
    hx_r     <= hx_nxt;
    mid_r    <= mid_nxt;
    target_r <= target_nxt;
    found_r  <= found_nxt;
    index_r  <= index_nxt;
    iters_r  <= iters_nxt;
    comps_r  <= comps_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    hx_nxt     = hx_r;
    mid_nxt    = mid_r;
    target_nxt = target_r;
    found_nxt  = found_r;
    index_nxt  = index_r;
    iters_nxt  = iters_r;
    comps_nxt  = comps_r;
    idle       = 1'b0;
    rd_en      = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      sbs_pkg::SBS_IDLE: begin
        idle = 1'b1;
        if (start) begin
          low_nxt    = '0;
          hx_nxt     = num_entries;
          target_nxt = target;
          found_nxt  = 1'b0;
          index_nxt  = '0;
          iters_nxt  = '0;
          comps_nxt  = '0;
          // empty table answers at once
          state_nxt  = (num_entries == '0) ? sbs_pkg::SBS_DONE : sbs_pkg::SBS_PROBE;
        end
      end
      sbs_pkg::SBS_PROBE: begin
        rd_en     = 1'b1;
        mid_nxt   = mid;
        state_nxt = sbs_pkg::SBS_COMPARE;
      end
      sbs_pkg::SBS_COMPARE: begin
        iters_nxt = (iters_r == '1) ? iters_r : iters_r + sbs_pkg::ITER_W'(1);
        comps_nxt = comps_add[sbs_pkg::COMP_W] ? '1 : comps_add[sbs_pkg::COMP_W-1:0];
        if (hit) begin
          found_nxt = 1'b1;
          index_nxt = sbs_pkg::INDEX_W'(mid_r);
          state_nxt = sbs_pkg::SBS_DONE;
        end else if (below) begin
          low_nxt   = mid_inc;
          state_nxt = (mid_inc < hx_r) ? sbs_pkg::SBS_PROBE : sbs_pkg::SBS_DONE;
        end else begin
          hx_nxt    = mid_r;
          state_nxt = (low_r < mid_r) ? sbs_pkg::SBS_PROBE : sbs_pkg::SBS_DONE;
        end
      end
      sbs_pkg::SBS_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = sbs_pkg::SBS_IDLE;
        end
      end
      default: begin
        state_nxt = sbs_pkg::SBS_IDLE;
      end
    endcase
  end

  assign rd_addr = ADDR_W'(mid);

  assign result.found            = found_r;
  assign result.found_index      = index_r;
  assign result.iteration_count  = iters_r;
  assign result.comparison_count = comps_r;

  // checks on the search sequence
  `SBS_ASSERT_IMP(a_compare_follows_probe, clk, rst_n,
    state_r == sbs_pkg::SBS_COMPARE, $past(state_r) == sbs_pkg::SBS_PROBE)
  `SBS_ASSERT_IMP(a_probe_range_nonempty, clk, rst_n,
    state_r == sbs_pkg::SBS_PROBE, low_r < hx_r)
  `SBS_ASSERT_IMP(a_miss_counts_two_each, clk, rst_n,
    state_r == sbs_pkg::SBS_DONE && !found_r && iters_r != 4'hF,
    comps_r == {iters_r, 1'b0})
  `SBS_ASSERT_NXT(a_start_leaves_idle, clk, rst_n,
    state_r == sbs_pkg::SBS_IDLE && start, state_r != sbs_pkg::SBS_IDLE)

endmodule

// ===== tb/tb_sorted_table_binary_search_unit.sv =====
// self-checking testbench for sorted_table_binary_search_unit: directed and random
// table writes and searches, checked against an internal binary search predictor
// depends on sbs_pkg and the sorted_table_binary_search_unit rtl
module tb_sorted_table_binary_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W       = sbs_pkg::VALUE_W;
  localparam int unsigned INDEX_W       = sbs_pkg::INDEX_W;
  localparam int unsigned COUNT_W       = sbs_pkg::COUNT_W;
  localparam int unsigned ITER_W        = sbs_pkg::ITER_W;
  localparam int unsigned COMP_W        = sbs_pkg::COMP_W;
  localparam int unsigned IN_DATA_W     = sbs_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W    = sbs_pkg::OUT_DATA_W;
  localparam int unsigned DEPTH         = sbs_pkg::DEFAULT_TABLE_DEPTH;
  localparam int unsigned RES_W         = $bits(sbs_pkg::sbs_result_t);
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned IDLE_PCT      = 31;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  // ascending ladder for the directed part, both extremes included
  localparam logic [VALUE_W-1:0] LADDER [8] = '{
    32'h8000_0000, 32'hFFFF_FC18, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0001, 32'h0000_0007, 32'h0000_03E8, 32'h7FFF_FFFF
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [9:0] entry_index, [41:10] value, [47:42] zero
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  // [0] mode
  logic                   in_tuser   = sbs_pkg::MODE_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] found, [10:1] found_index, [14:11] iteration_count,
  // [19:15] comparison_count, [23:20] zero
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [COUNT_W-1:0]     cfg_data   = '0;

  bit          no_gaps    = 1'b0;
  int unsigned items_sent = 0;

  // ascending values that fill table gaps just before a search reaches them
  logic [VALUE_W-1:0] backdrop [DEPTH];

  // shadow table, entry count and the queue of search results still owed
  class search_checker;
    logic signed [VALUE_W-1:0] shadow_entries [DEPTH];
    bit                        written [DEPTH];
    logic [COUNT_W-1:0]        entry_count;
    sbs_pkg::sbs_result_t      awaited [$];
    int unsigned               failures;

    function new();
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
      foreach (written[i]) written[i] = 1'b0;
      entry_count = '0;
      failures    = 0;
    endfunction

    function void load_entry_count(logic [COUNT_W-1:0] v);
      entry_count = v;
    endfunction

    // equality first, then less-than, on the rounded-down midpoint
    function sbs_pkg::sbs_result_t predict_lookup(logic signed [VALUE_W-1:0] target);
      int                   lo, hi, mid, n;
      int unsigned          probes, compares;
      sbs_pkg::sbs_result_t r;
      n  = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
      lo = 0;
      hi = n - 1;
      probes   = 0;
      compares = 0;
      r = '0;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        probes++;
        compares++;
        if (shadow_entries[mid] == target) begin
          r.found       = 1'b1;
          r.found_index = mid[INDEX_W-1:0];
          break;
        end
        compares++;
        if (shadow_entries[mid] < target) lo = mid + 1;
        else hi = mid - 1;
      end
      r.iteration_count  = (probes > 15) ? 4'd15 : ITER_W'(probes);
      r.comparison_count = (compares > 31) ? 5'd31 : COMP_W'(compares);
      return r;
    endfunction

    // first probe of a search that lands on a never-written entry, or -1
    function int first_gap(logic signed [VALUE_W-1:0] target);
      int lo, hi, mid, n;
      n  = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (!written[mid]) return mid;
        if (shadow_entries[mid] == target) return -1;
        if (shadow_entries[mid] < target) lo = mid + 1;
        else hi = mid - 1;
      end
      return -1;
    endfunction

    function void note_request(logic mode, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] value);
      if (mode == sbs_pkg::MODE_WRITE) begin
        if (idx < DEPTH) begin
          shadow_entries[idx] = value;
          written[idx]        = 1'b1;
        end
      end else begin
        awaited = {awaited, predict_lookup(value)};
      end
    endfunction

    function void check_response(logic [OUT_DATA_W-1:0] data);
      sbs_pkg::sbs_result_t        want;
      sbs_pkg::sbs_result_t        got;
      logic [OUT_DATA_W-RES_W-1:0] pad;
      got = data[RES_W-1:0];
      pad = data[OUT_DATA_W-1:RES_W];
      if (awaited.size() == 0) begin
        $error("result with no search pending: tdata %h", data);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        failures++;
      end
      if (got.found_index !== want.found_index) begin
        $error("found_index: expected %0d, actual %0d", want.found_index, got.found_index);
        failures++;
      end
      if (got.iteration_count !== want.iteration_count) begin
        $error("iteration_count: expected %0d, actual %0d",
               want.iteration_count, got.iteration_count);
        failures++;
      end
      if (got.comparison_count !== want.comparison_count) begin
        $error("comparison_count: expected %0d, actual %0d",
               want.comparison_count, got.comparison_count);
        failures++;
      end
      if (pad !== '0) begin
        $error("tdata padding: expected 0, actual %h", pad);
        failures++;
      end
    endfunction
  endclass

  search_checker sb;

  sorted_table_binary_search_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check each transaction, then stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
      out_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // ascending gap values spread over the full signed range
  function automatic void plan_backdrop();
    longint v;
    v = -64'sd2147483648 + longint'($urandom_range(4095));
    for (int i = 0; i < DEPTH; i++) begin
      backdrop[i] = v[VALUE_W-1:0];
      v += longint'($urandom_range(6291455));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_request(logic mode, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] value);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_DATA_W-VALUE_W-INDEX_W){1'b0}}, value, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, idx, value);
    items_sent++;
  endtask

  // write every entry the search would probe unwritten, then search
  task automatic search_for(logic [VALUE_W-1:0] target);
    int gap;
    gap = sb.first_gap(target);
    while (gap >= 0) begin
      send_request(sbs_pkg::MODE_WRITE, INDEX_W'(gap), backdrop[gap]);
      gap = sb.first_gap(target);
    end
    send_request(sbs_pkg::MODE_SEARCH, INDEX_W'($urandom_range(DEPTH-1)), target);
  endtask

  // let every search finish, plus slack for a write still in flight
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_entry_count(int unsigned v);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.load_entry_count(COUNT_W'(v));
  endtask

  // write entries 0..n-1 ascending, either dense or spread over the full range,
  // or scrambled to break the ordering
  task automatic fill_ascending(int unsigned n, bit spread, bit scrambled);
    longint v, step_max;
    if (spread) begin
      step_max = 64'sd8589934592 / n;
      v = -64'sd2147483648 + longint'($urandom()) % step_max;
    end else begin
      step_max = 3;
      v = longint'($signed($urandom()));
    end
    for (int unsigned i = 0; i < n; i++) begin
      send_request(sbs_pkg::MODE_WRITE, INDEX_W'(i),
                   scrambled ? $urandom() : v[VALUE_W-1:0]);
      v += longint'($urandom()) % (step_max + 1);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
  endtask

  // mostly present entries and their neighbors, some arbitrary targets
  function automatic logic [VALUE_W-1:0] pick_target(int unsigned n);
    int unsigned        r;
    int unsigned        idx;
    logic [VALUE_W-1:0] v;
    r = $urandom_range(99);
    if (n > DEPTH) n = DEPTH;
    if (r < 3) return VALUE_MIN;
    if (r < 6) return VALUE_MAX;
    if (n == 0 || r < 20) return $urandom();
    idx = $urandom_range(n-1);
    v = sb.written[idx] ? sb.shadow_entries[idx] : backdrop[idx];
    if (r < 65) return v;
    if (r < 82) return v + 1;
    return v - 1;
  endfunction

  task automatic run_random_phase();
    int unsigned n, span, r;
    no_gaps = ($urandom_range(9) == 0);
    r = $urandom_range(99);
    if (r < 6) n = 0;
    else if (r < 12) n = 1;
    else if (r < 18) n = $urandom_range(200, 65);
    else n = $urandom_range(40, 2);
    program_entry_count(n);
    if (n != 0) fill_ascending(n, $urandom_range(1), $urandom_range(99) < 12);
    span = n;
    // occasionally search past the fresh entries into older content
    if ($urandom_range(99) < 8) begin
      span = $urandom_range(DEPTH, n);
      program_entry_count(span);
    end
    repeat ($urandom_range(16, 4)) search_for(pick_target(span));
  endtask

  // main stimulus
  initial begin
    int unsigned start_mark;
    sb = new();
    plan_backdrop();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table right after reset
    search_for(VALUE_MIN);
    search_for('0);

    // small ascending table, plus the top index
    for (int i = 0; i < 8; i++) send_request(sbs_pkg::MODE_WRITE, INDEX_W'(i), LADDER[i]);
    send_request(sbs_pkg::MODE_WRITE, '1, 32'h5555_5555);
    program_entry_count(8);
    search_for(LADDER[0]);
    search_for(LADDER[7]);
    search_for(LADDER[3]);
    search_for(LADDER[6]);
    search_for(32'd2);
    search_for(32'h8000_0001);

    // single entry table
    program_entry_count(1);
    search_for(LADDER[0]);
    search_for(32'd5);

    // out of order entry, search misses entries that are present
    send_request(sbs_pkg::MODE_WRITE, 10'd2, 32'd5000);
    program_entry_count(8);
    search_for(32'd5000);
    search_for(LADDER[2]);

    // full depth with no idle cycles, then a count beyond the depth
    no_gaps = 1'b1;
    program_entry_count(DEPTH);
    repeat (15) search_for(pick_target(DEPTH));
    program_entry_count((1 << COUNT_W) - 1);
    search_for(VALUE_MIN);
    search_for(VALUE_MAX);
    repeat (8) search_for(pick_target(DEPTH));
    no_gaps = 1'b0;

    // random phases; table gaps are written before a search reaches them
    start_mark = items_sent;
    while (items_sent - start_mark < RANDOM_ITEMS) run_random_phase();
    no_gaps = 1'b0;

    wait_for_idle();
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sbs_pkg.sv
design/sbs_table_ram.sv
design/sbs_search_ctrl.sv
design/sorted_table_binary_search_unit.sv
tb/tb_sorted_table_binary_search_unit.sv
